// ===== rtl/assert_macros.svh =====
// Assertion macros for the multicast group member table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property that must hold at every clock edge outside reset.
`define GMT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");
// Condition that implies another one on the next clock edge.
`define GMT_ASSERT_NEXT(lbl, cond, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error("assertion failed");
`else
`define GMT_ASSERT(lbl, prop)
`define GMT_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ===== rtl/gmt_pkg.sv =====
// Shared types and constants of the multicast group member table.
`timescale 1ns / 1ps
package gmt_pkg;

   localparam logic [31:0] BROADCAST_ADDR = 32'hFFFF_FFFF;

   typedef enum logic [2:0] {
      OP_SET_ROLE  = 3'd0,
      OP_REMOVE    = 3'd1,
      OP_PACKET    = 3'd2,
      OP_ADAPT     = 3'd3,
      OP_TOUCH     = 3'd4,
      OP_SET_IVAL  = 3'd5,
      OP_QUERY     = 3'd6,
      OP_QUERY_ALT = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_FOUND = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_BROADCAST = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_FIND, ST_MOD, ST_SHIFT, ST_SCAN, ST_DONE
   } state_type;

   typedef struct packed {
      logic [31:0] group;
      logic [7:0]  role;
      logic [15:0] interval;
      logic [31:0] refreshed_at;
      logic [31:0] last_packet;
   } entry_type;

   typedef struct packed {
      logic [15:0] min_ival;
      logic [15:0] max_ival;
      logic [7:0]  src_code;
      logic [7:0]  fwd_code;
   } cfg_type;

   typedef struct packed {
      logic       we;
      logic       append;
      logic       remove;
      status_type status;
      logic       found;
      entry_type  ent;
   } alu_res_type;

endpackage

// ===== rtl/multicast_group_member_table.sv =====
// Top level of the multicast group member table.
//
// Input items arrive on req_ (tvalid/tready/tdata); each names one operation
// on one group. Exactly one result item leaves on rsp_ for each input item.
// Configuration registers are written through csr_we/csr_index/csr_wdata
// by the user only while the block is idle; the block does not enforce this.
//
// Every item walks a sequencer around one entry memory: a search pass that
// reads one occupied entry per cycle, a read-modify-write state, a shift pass
// that moves one later entry per cycle on remove, then a role scan pass that
// reads one occupied entry per cycle. Each pass also waits for the registered
// read data and the end check.
//
// Reset empties the table and loads the register defaults; no clearing pass
// is needed. The result sits in an output register; while the receiver
// stalls, the next item is taken and worked up to the point of delivery.
`timescale 1ns / 1ps
module multicast_group_member_table #(
   parameter int TABLE_ENTRIES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // mode[2:0], group_addr[34:3], new_role[42:35], interval_value[58:43],
   // now_sec[90:59], zero fill
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], found[2], entry_role[10:3], entry_interval[26:11],
   // entry_last_packet[58:27], any_source[59], any_receiver[60],
   // source_group[92:61], receiver_group[124:93], entry_count[129:125], zero fill
   output logic [135:0] rsp_tdata,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [15:0]  csr_wdata
);
   import gmt_pkg::*;

   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int CW = $clog2(TABLE_ENTRIES + 1);
   localparam logic [1:0] CSR_MIN = 2'd0;
   localparam logic [1:0] CSR_MAX = 2'd1;
   localparam logic [1:0] CSR_SRC = 2'd2;
   localparam logic [1:0] CSR_FWD = 2'd3;

   state_type   state_ff, state_in;
   cfg_type     cfg_ff;
   logic [CW-1:0] count_ff, count_in;

   // latched request
   op_type      op_ff;
   logic [31:0] grp_ff, now_ff;
   logic [7:0]  role_ff;
   logic [15:0] ival_ff;

   // scan engine
   logic [CW:0]   iss_ff, limit;
   logic          pipe_v_ff;
   logic [AW-1:0] pipe_idx_ff;
   logic          in_pass, issue, scan_done;

   // search and result registers
   logic          hit_ff;
   logic [AW-1:0] hit_idx_ff;
   entry_type     hit_ent_ff;
   alu_res_type   alu_res;
   status_type    res_status_ff;
   logic          res_found_ff;
   entry_type     res_ent_ff;
   logic          any_src_ff, any_rcv_ff;
   logic [31:0]   src_grp_ff, rcv_grp_ff;
   logic          rsp_valid_ff;

   // memory ports
   logic          mem_we, mem_re;
   logic [AW-1:0] mem_waddr, mem_raddr;
   entry_type     mem_wdata, mem_rdata;

   gmt_ram #(.DEPTH(TABLE_ENTRIES), .AW(AW)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   gmt_alu u_alu (
      .op       (op_ff),
      .hit      (hit_ff),
      .full     (count_ff == CW'(TABLE_ENTRIES)),
      .ent      (hit_ent_ff),
      .grp      (grp_ff),
      .new_role (role_ff),
      .ival     (ival_ff),
      .now      (now_ff),
      .cfg      (cfg_ff),
      .res      (alu_res)
   );

   // scan pass issue control; shift pass runs to the count before removal
   assign limit     = (state_ff == ST_SHIFT) ? ({1'b0, count_ff} + 1'b1) : {1'b0, count_ff};
   assign in_pass   = (state_ff == ST_FIND) || (state_ff == ST_SCAN) ||
                      (state_ff == ST_SHIFT);
   assign issue     = in_pass && (iss_ff < limit);
   assign scan_done = !issue && !pipe_v_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) state_in = ST_FIND;
         ST_FIND:  if (scan_done) state_in = ST_MOD;
         ST_MOD:   state_in = alu_res.remove ? ST_SHIFT : ST_SCAN;
         ST_SHIFT: if (scan_done) state_in = ST_SCAN;
         ST_SCAN:  if (scan_done) state_in = ST_DONE;
         ST_DONE:  if (!rsp_valid_ff || rsp_tready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // memory control
   always_comb begin
      mem_re    = issue;
      mem_raddr = iss_ff[AW-1:0];
      mem_we    = 1'b0;
      mem_waddr = pipe_idx_ff - 1'b1;
      mem_wdata = mem_rdata;
      unique case (state_ff)
         ST_MOD: begin
            mem_we    = alu_res.we;
            mem_waddr = alu_res.append ? count_ff[AW-1:0] : hit_idx_ff;
            mem_wdata = alu_res.ent;
         end
         ST_SHIFT: mem_we = pipe_v_ff;
         ST_IDLE, ST_FIND, ST_SCAN, ST_DONE: begin
         end
         default: begin
         end
      endcase
   end

   // occupancy
   always_comb begin
      count_in = count_ff;
      if (state_ff == ST_MOD) begin
         if (alu_res.append) count_in = count_ff + 1'b1;
         else if (alu_res.remove) count_in = count_ff - 1'b1;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pipe_v_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '{min_ival: 16'd1, max_ival: 16'd60, src_code: 8'd1, fwd_code: 8'd3};
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pipe_v_ff <= issue;
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_tready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_MIN: cfg_ff.min_ival <= csr_wdata;
               CSR_MAX: cfg_ff.max_ival <= csr_wdata;
               CSR_SRC: cfg_ff.src_code <= csr_wdata[7:0];
               CSR_FWD: cfg_ff.fwd_code <= csr_wdata[7:0];
               default: begin
               end
            endcase
         end
      end
   end

   // request, scan and result payload
   always_ff @(posedge clock) begin
      pipe_idx_ff <= iss_ff[AW-1:0];
      if (issue) iss_ff <= iss_ff + 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            op_ff      <= op_type'(req_tdata[2:0]);
            grp_ff     <= req_tdata[34:3];
            role_ff    <= req_tdata[42:35];
            ival_ff    <= req_tdata[58:43];
            now_ff     <= req_tdata[90:59];
            iss_ff     <= '0;
            hit_ff     <= 1'b0;
            hit_idx_ff <= '0;
         end
         ST_FIND: begin
            // first entry that carries the group
            if (pipe_v_ff && !hit_ff && mem_rdata.group == grp_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= pipe_idx_ff;
               hit_ent_ff <= mem_rdata;
            end
         end
         ST_MOD: begin
            res_status_ff <= alu_res.status;
            res_found_ff  <= alu_res.found;
            res_ent_ff    <= alu_res.ent;
            iss_ff        <= alu_res.remove ? ({1'b0, CW'(hit_idx_ff)} + 1'b1) : '0;
            any_src_ff    <= 1'b0;
            any_rcv_ff    <= 1'b0;
            src_grp_ff    <= '0;
            rcv_grp_ff    <= '0;
         end
         ST_SHIFT: begin
            if (scan_done) iss_ff <= '0;
         end
         ST_SCAN: begin
            // first source and first receiver in insertion order
            if (pipe_v_ff) begin
               if (!any_src_ff && mem_rdata.role == cfg_ff.src_code) begin
                  any_src_ff <= 1'b1;
                  src_grp_ff <= mem_rdata.group;
               end
               if (!any_rcv_ff && mem_rdata.role < cfg_ff.fwd_code &&
                   mem_rdata.role != cfg_ff.src_code) begin
                  any_rcv_ff <= 1'b1;
                  rcv_grp_ff <= mem_rdata.group;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_tdata <= {6'd0, 5'(count_ff), rcv_grp_ff, src_grp_ff, any_rcv_ff,
                             any_src_ff,
                             res_found_ff ? res_ent_ff.last_packet : 32'd0,
                             res_found_ff ? res_ent_ff.interval : 16'd0,
                             res_found_ff ? res_ent_ff.role : 8'd0,
                             res_found_ff, res_status_ff};
            end
         end
         default: begin
         end
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

`include "assert_macros.svh"

   `GMT_ASSERT(a_count_bound, count_ff <= CW'(TABLE_ENTRIES))
   `GMT_ASSERT(a_pipe_in_pass, !pipe_v_ff || in_pass)
   `GMT_ASSERT(a_hit_in_table, !(state_ff == ST_MOD && hit_ff) || ({1'b0, hit_idx_ff} < (AW+1)'(count_ff)))
   `GMT_ASSERT_NEXT(a_accept_starts, req_tvalid && req_tready, state_ff == ST_FIND)
endmodule

// ===== rtl/gmt_ram.sv =====
// Entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module gmt_ram #(
   parameter int DEPTH = 16,
   parameter int AW    = 4
) (
   input  logic              clock,
   input  logic              we,
   input  logic [AW-1:0]     waddr,
   input  gmt_pkg::entry_type wdata,
   input  logic              re,
   input  logic [AW-1:0]     raddr,
   output gmt_pkg::entry_type rdata
);
   import gmt_pkg::*;

   entry_type mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end
endmodule

// ===== rtl/gmt_alu.sv =====
// Per-operation update of the matched entry and result status.
`timescale 1ns / 1ps
module gmt_alu (
   input  gmt_pkg::op_type      op,
   input  logic                 hit,
   input  logic                 full,
   input  gmt_pkg::entry_type   ent,
   input  logic [31:0]          grp,
   input  logic [7:0]           new_role,
   input  logic [15:0]          ival,
   input  logic [31:0]          now,
   input  gmt_pkg::cfg_type     cfg,
   output gmt_pkg::alu_res_type res
);
   import gmt_pkg::*;

   logic [31:0] diff;
   logic [16:0] dbl;
   logic [15:0] adapt_ival;

   // adaptive interval
   always_comb begin
      diff = now - ent.refreshed_at;
      dbl  = {ent.interval, 1'b0};
      if (ent.refreshed_at == 32'd0) begin
         adapt_ival = cfg.min_ival;
      end else if ($signed(diff) < $signed({16'd0, cfg.min_ival})) begin
         adapt_ival = cfg.min_ival;
      end else if ($signed(diff) >= $signed({16'd0, ent.interval})) begin
         adapt_ival = (dbl > {1'b0, cfg.max_ival}) ? cfg.max_ival : dbl[15:0];
      end else begin
         adapt_ival = diff[15:0];
      end
   end

   always_comb begin
      res        = '0;
      res.ent    = ent;
      res.status = hit ? STAT_OK : STAT_NOT_FOUND;
      res.found  = hit;
      unique case (op)
         OP_SET_ROLE: begin
            if (hit) begin
               res.we       = 1'b1;
               res.ent.role = new_role;
            end else if (grp == BROADCAST_ADDR) begin
               res.status = STAT_BROADCAST;
            end else if (full) begin
               res.status = STAT_FULL;
            end else begin
               res.status  = STAT_OK;
               res.found   = 1'b1;
               res.we      = 1'b1;
               res.append  = 1'b1;
               res.ent     = '{group: grp, role: new_role, interval: cfg.min_ival,
                               refreshed_at: 32'd0, last_packet: 32'd0};
            end
         end
         OP_REMOVE: begin
            res.remove = hit;
            res.found  = 1'b0;
         end
         OP_PACKET: begin
            res.we              = hit;
            res.ent.last_packet = now;
         end
         OP_ADAPT: begin
            res.we               = hit;
            res.ent.interval     = adapt_ival;
            res.ent.refreshed_at = now;
         end
         OP_TOUCH: begin
            res.we               = hit;
            res.ent.refreshed_at = now;
         end
         OP_SET_IVAL: begin
            res.we           = hit;
            res.ent.interval = ival;
         end
         OP_QUERY, OP_QUERY_ALT: begin
         end
         default: begin
         end
      endcase
   end
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the multicast group member table.
`timescale 1ns / 1ps
module testbench;
   import gmt_pkg::*;

   localparam int ENTRIES = 16;

   // Register indexes
   localparam logic [1:0] REG_MIN_IVAL = 2'd0;
   localparam logic [1:0] REG_MAX_IVAL = 2'd1;
   localparam logic [1:0] REG_SRC_CODE = 2'd2;
   localparam logic [1:0] REG_FWD_CODE = 2'd3;

   // Result item, highest field first
   typedef struct packed {
      logic [4:0]  count;
      logic [31:0] rcv_group;
      logic [31:0] src_group;
      logic        any_rcv;
      logic        any_src;
      logic [31:0] last_packet;
      logic [15:0] interval;
      logic [7:0]  role;
      logic        found;
      logic [1:0]  status;
   } table_reply_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [135:0] rsp_tdata;
   logic         csr_we;
   logic [1:0]   csr_index;
   logic [15:0]  csr_wdata;

   // Shadow copy of the table and registers
   logic [31:0] sh_group[ENTRIES];
   logic [7:0]  sh_role[ENTRIES];
   logic [15:0] sh_ival[ENTRIES];
   logic [31:0] sh_refresh[ENTRIES];
   logic [31:0] sh_packet[ENTRIES];
   int          sh_count;
   logic [15:0] min_ival, max_ival;
   logic [7:0]  src_code, fwd_code;

   table_reply_type expected_replies[$];
   logic [31:0]  known_groups[$];
   int           errors;
   bit           hold_rsp;
   int           hold_cycles;

   multicast_group_member_table u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   initial begin
      #200ms;
      $display("FAILURE");
      $finish;
   end

   // Short gaps mostly, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   function automatic int find_group(logic [31:0] grp);
      for (int i = 0; i < sh_count; i++)
         if (sh_group[i] == grp) return i;
      return -1;
   endfunction

   // Apply one operation to the shadow table and build the reply
   function automatic table_reply_type predict_table(logic [2:0] mode, logic [31:0] grp,
                                                     logic [7:0] role, logic [15:0] ival,
                                                     logic [31:0] now);
      table_reply_type rep;
      int           idx;
      logic [31:0]  diff;
      logic [16:0]  dbl;
      idx = find_group(grp);
      rep = '0;
      rep.status = STAT_OK;
      case (op_type'(mode))
         OP_SET_ROLE: begin
            if (idx >= 0) sh_role[idx] = role;
            else if (grp == BROADCAST_ADDR) rep.status = STAT_BROADCAST;
            else if (sh_count >= ENTRIES) rep.status = STAT_FULL;
            else begin
               idx = sh_count;
               sh_group[idx] = grp;
               sh_role[idx] = role;
               sh_ival[idx] = min_ival;
               sh_refresh[idx] = '0;
               sh_packet[idx] = '0;
               sh_count++;
            end
         end
         OP_REMOVE: begin
            if (idx < 0) rep.status = STAT_NOT_FOUND;
            else begin
               for (int i = idx; i + 1 < sh_count; i++) begin
                  sh_group[i] = sh_group[i+1];
                  sh_role[i] = sh_role[i+1];
                  sh_ival[i] = sh_ival[i+1];
                  sh_refresh[i] = sh_refresh[i+1];
                  sh_packet[i] = sh_packet[i+1];
               end
               sh_count--;
               idx = -1;
            end
         end
         OP_PACKET: begin
            if (idx < 0) rep.status = STAT_NOT_FOUND;
            else sh_packet[idx] = now;
         end
         OP_ADAPT: begin
            if (idx < 0) rep.status = STAT_NOT_FOUND;
            else if (sh_refresh[idx] == 0) begin
               sh_ival[idx] = min_ival;
               sh_refresh[idx] = now;
            end else begin
               diff = now - sh_refresh[idx];
               sh_refresh[idx] = now;
               dbl = {1'b0, sh_ival[idx]} << 1;
               if ($signed(diff) < $signed({16'd0, min_ival})) sh_ival[idx] = min_ival;
               else if ($signed(diff) >= $signed({16'd0, sh_ival[idx]})) begin
                  if (dbl > {1'b0, max_ival}) sh_ival[idx] = max_ival;
                  else sh_ival[idx] = dbl[15:0];
               end else sh_ival[idx] = diff[15:0];
            end
         end
         OP_TOUCH: begin
            if (idx < 0) rep.status = STAT_NOT_FOUND;
            else sh_refresh[idx] = now;
         end
         OP_SET_IVAL: begin
            if (idx < 0) rep.status = STAT_NOT_FOUND;
            else sh_ival[idx] = ival;
         end
         default: if (idx < 0) rep.status = STAT_NOT_FOUND;
      endcase
      // Role scan in insertion order
      for (int i = 0; i < sh_count; i++) begin
         if (!rep.any_src && sh_role[i] == src_code) begin
            rep.any_src = 1'b1;
            rep.src_group = sh_group[i];
         end
         if (!rep.any_rcv && sh_role[i] < fwd_code && sh_role[i] != src_code) begin
            rep.any_rcv = 1'b1;
            rep.rcv_group = sh_group[i];
         end
      end
      if (idx >= 0) begin
         rep.found = 1'b1;
         rep.role = sh_role[idx];
         rep.interval = sh_ival[idx];
         rep.last_packet = sh_packet[idx];
      end
      rep.count = sh_count[4:0];
      return rep;
   endfunction

   // Offer one item, predict at acceptance; valid stays up for a following item
   task automatic send_item(logic [2:0] mode, logic [31:0] grp, logic [7:0] role,
                            logic [15:0] ival, logic [31:0] now);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {5'd0, now, ival, role, grp, mode};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_replies.push_back(predict_table(mode, grp, role, ival, now));
      if (mode == OP_SET_ROLE && grp != BROADCAST_ADDR) known_groups.push_back(grp);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [1:0] index, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         REG_MIN_IVAL: min_ival = value;
         REG_MAX_IVAL: max_ival = value;
         REG_SRC_CODE: src_code = value[7:0];
         default:      fwd_code = value[7:0];
      endcase
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_group();
      if (known_groups.size() != 0 && $urandom_range(0, 9) < 8)
         return known_groups[$urandom_range(0, known_groups.size() - 1)];
      if ($urandom_range(0, 19) == 0) return BROADCAST_ADDR;
      return $urandom();
   endfunction

   // Receiver stall pattern
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else if (hold_rsp) rsp_tready <= 1'b0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) hold_cycles <= pick_gap();
      end
   end

   // Compare each accepted result with the oldest expectation
   always @(posedge clock) begin
      table_reply_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[129:0];
         if (expected_replies.size() == 0) begin
            $display("%0t: result with nothing expected: %h", $time, got);
            errors++;
         end else begin
            want = expected_replies.pop_front();
            if (got.status !== want.status)
               $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
            if (got.found !== want.found)
               $display("%0t: found exp %0d got %0d", $time, want.found, got.found);
            if (got.role !== want.role)
               $display("%0t: role exp %0d got %0d", $time, want.role, got.role);
            if (got.interval !== want.interval)
               $display("%0t: interval exp %0d got %0d", $time, want.interval, got.interval);
            if (got.last_packet !== want.last_packet)
               $display("%0t: last packet exp %h got %h", $time, want.last_packet,
                        got.last_packet);
            if (got.any_src !== want.any_src)
               $display("%0t: any source exp %0d got %0d", $time, want.any_src, got.any_src);
            if (got.any_rcv !== want.any_rcv)
               $display("%0t: any receiver exp %0d got %0d", $time, want.any_rcv, got.any_rcv);
            if (got.src_group !== want.src_group)
               $display("%0t: source group exp %h got %h", $time, want.src_group,
                        got.src_group);
            if (got.rcv_group !== want.rcv_group)
               $display("%0t: receiver group exp %h got %h", $time, want.rcv_group,
                        got.rcv_group);
            if (got.count !== want.count)
               $display("%0t: count exp %0d got %0d", $time, want.count, got.count);
            if (got !== want) errors++;
         end
      end
   end

   // Edges of every field, each operation, full table and broadcast
   task automatic test_directed();
      logic [31:0] g;
      send_item(OP_REMOVE, 32'h0, 8'h0, 16'h0, 32'h0);
      send_item(OP_SET_ROLE, BROADCAST_ADDR, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
      send_item(OP_SET_ROLE, 32'h0, 8'h0, 16'h0, 32'h0);
      send_item(OP_SET_ROLE, 32'hE000_0001, 8'd1, 16'h0, 32'h0);
      send_item(OP_SET_ROLE, 32'hFFFF_FFFE, 8'hFF, 16'h0, 32'h0);
      send_item(OP_PACKET, 32'hE000_0001, 8'h0, 16'h0, 32'hFFFF_FFFF);
      send_item(OP_ADAPT, 32'hE000_0001, 8'h0, 16'h0, 32'd100);
      send_item(OP_ADAPT, 32'hE000_0001, 8'h0, 16'h0, 32'd200);
      send_item(OP_ADAPT, 32'hE000_0001, 8'h0, 16'h0, 32'd50);
      send_item(OP_SET_IVAL, 32'hFFFF_FFFE, 8'h0, 16'hFFFF, 32'h0);
      send_item(OP_TOUCH, 32'hFFFF_FFFE, 8'h0, 16'h0, 32'd10);
      send_item(OP_ADAPT, 32'hFFFF_FFFE, 8'h0, 16'h0, 32'd20);
      send_item(OP_QUERY, 32'h0, 8'h0, 16'h0, 32'h0);
      send_item(OP_QUERY_ALT, 32'h1234_5678, 8'h0, 16'h0, 32'h0);
      send_item(OP_SET_ROLE, 32'h0, 8'd2, 16'h0, 32'h0);
      for (int i = 0; i < 14; i++) send_item(OP_SET_ROLE, 32'hEF00_0000 + i, 8'd2, 16'h0, 32'h0);
      send_item(OP_SET_ROLE, 32'hEFFF_0000, 8'd0, 16'h0, 32'h0);
      send_item(OP_REMOVE, 32'hEF00_000D, 8'h0, 16'h0, 32'h0);
      send_item(OP_REMOVE, 32'h0, 8'h0, 16'h0, 32'h0);
      // Empty the table again
      while (sh_count > 0) begin
         g = sh_group[sh_count - 1];
         send_item(OP_REMOVE, g, 8'h0, 16'h0, 32'h0);
      end
      drain();
   endtask

   // Random operations, mostly on groups already seen
   task automatic test_random(int count);
      logic [2:0]  mode;
      logic [31:0] now;
      for (int n = 0; n < count; n++) begin
         mode = 3'($urandom_range(0, 7));
         if (sh_count > 12 && $urandom_range(0, 1) == 0) mode = OP_REMOVE;
         now = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 300);
         send_item(mode, pick_group(), $urandom_range(0, 255) < 200 ?
                   8'($urandom_range(0, 4)) : 8'($urandom()),
                   16'($urandom()), now);
      end
      drain();
   endtask

   // Receiver held off while items keep coming
   task automatic test_backpressure();
      hold_rsp = 1'b1;
      fork
         test_random(8);
         begin
            repeat (400) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join
   endtask

   initial begin
      errors = 0;
      hold_rsp = 1'b0;
      hold_cycles = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = REG_MIN_IVAL;
      csr_wdata = '0;
      sh_count = 0;
      min_ival = 16'd1;
      max_ival = 16'd60;
      src_code = 8'd1;
      fwd_code = 8'd3;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random(250);
      test_backpressure();
      write_reg(REG_MIN_IVAL, 16'hFFFF);
      write_reg(REG_MAX_IVAL, 16'd1);
      write_reg(REG_SRC_CODE, 16'h00FF);
      write_reg(REG_FWD_CODE, 16'h00FF);
      test_random(250);
      write_reg(REG_MIN_IVAL, 16'd1);
      write_reg(REG_MAX_IVAL, 16'hFFFF);
      write_reg(REG_SRC_CODE, 16'h0000);
      write_reg(REG_FWD_CODE, 16'h0000);
      test_random(250);
      write_reg(REG_MIN_IVAL, 16'd3);
      write_reg(REG_MAX_IVAL, 16'd40);
      write_reg(REG_SRC_CODE, 16'd2);
      write_reg(REG_FWD_CODE, 16'd4);
      test_random(250);

      if (errors == 0 && expected_replies.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
